FILE: rtl/sitm_pkg.sv
// sitm_pkg: shared constants and types for the spatial inertia twist multiply unit
// no dependencies; imported by sitm_lane and spatial_inertia_twist_multiply_unit
`default_nettype none

package sitm_pkg;

  localparam int DataWidth  = 32;
  localparam int FracBits   = 16;
  localparam int FieldW     = 32;
  localparam int StoreDepth = 27;
  localparam int IdxW       = 5;
  localparam int MBase      = 0;
  localparam int HBase      = 9;
  localparam int JBase      = 18;
  localparam int NumLanes   = 6;
  localparam int NumTerms   = 6;
  localparam int ProdW      = 2 * FieldW;
  localparam int PairW      = ProdW + 1;
  localparam int AccW       = ProdW + 3;
  localparam int ResW       = (DataWidth < FieldW) ? DataWidth : FieldW;

  localparam logic KindLoad     = 1'b0;
  localparam logic KindMultiply = 1'b1;

  typedef logic signed [FieldW-1:0] field_t;

endpackage

`default_nettype wire

FILE: rtl/sitm_lane.sv
// sitm_lane: one result component, six products, adder tree, floor shift and saturation
// depends on sitm_pkg
`default_nettype none

module sitm_lane import sitm_pkg::*; (
  input  logic   clk_i,
  input  logic   adv_i,
  input  field_t coef_i  [NumTerms],
  input  field_t twist_i [NumTerms],
  output field_t res_o,
  output logic   sat_o
);

  localparam logic signed [AccW-1:0] ResMax = {{(AccW-ResW+1){1'b0}}, {(ResW-1){1'b1}}};
  localparam logic signed [AccW-1:0] ResMin = ~ResMax;

  logic signed [ProdW-1:0] prod_q [NumTerms];
  logic signed [PairW-1:0] pair_q [NumTerms/2];
  logic signed [AccW-1:0]  sum_q;
  logic signed [AccW-1:0]  shifted;
  logic                    over;
  logic                    under;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < NumTerms; k++) begin
        prod_q[k] <= coef_i[k] * twist_i[k];
      end
      for (int j = 0; j < NumTerms/2; j++) begin
        pair_q[j] <= {prod_q[2*j][ProdW-1], prod_q[2*j]}
                   + {prod_q[2*j+1][ProdW-1], prod_q[2*j+1]};
      end
      sum_q <= {{2{pair_q[0][PairW-1]}}, pair_q[0]}
             + {{2{pair_q[1][PairW-1]}}, pair_q[1]}
             + {{2{pair_q[2][PairW-1]}}, pair_q[2]};
    end
  end

  // floor by the fraction bits, then clip to the result range
  always_comb begin
    shifted = sum_q >>> FracBits;
    over    = shifted > ResMax;
    under   = shifted < ResMin;
    if (over) begin
      res_o = ResMax[FieldW-1:0];
    end else if (under) begin
      res_o = ResMin[FieldW-1:0];
    end else begin
      res_o = shifted[FieldW-1:0];
    end
    sat_o = over | under;
  end

endmodule

`default_nettype wire

FILE: rtl/spatial_inertia_twist_multiply_unit.sv
// spatial_inertia_twist_multiply_unit: inertia store, six parallel lanes, merge and output stage
// depends on sitm_pkg and sitm_lane
//
//  channel | signals                                   | dir
//  in      | in_valid_i, in_ready_o, kind_i ... lin_z_i | request in
//  out     | out_valid_o, out_ready_i, force_x_o ...    | request out
//
// one request per cycle unless the output stalls; a multiply request reaches the output
// through the input stage, product stage, pair sums, total and output register
// reset clears the inertia store and all stage valid bits at once
// a stalled output freezes every stage and holds in_ready_o low
`default_nettype none

module spatial_inertia_twist_multiply_unit import sitm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   kind_i,
  input  logic [IdxW-1:0]        entry_index_i,
  input  logic signed [FieldW-1:0] entry_value_i,
  input  logic signed [FieldW-1:0] ang_x_i,
  input  logic signed [FieldW-1:0] ang_y_i,
  input  logic signed [FieldW-1:0] ang_z_i,
  input  logic signed [FieldW-1:0] lin_x_i,
  input  logic signed [FieldW-1:0] lin_y_i,
  input  logic signed [FieldW-1:0] lin_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [FieldW-1:0] force_x_o,
  output logic signed [FieldW-1:0] force_y_o,
  output logic signed [FieldW-1:0] force_z_o,
  output logic signed [FieldW-1:0] torque_x_o,
  output logic signed [FieldW-1:0] torque_y_o,
  output logic signed [FieldW-1:0] torque_z_o,
  output logic                   saturated_o
);

  field_t     store_q  [StoreDepth];
  field_t     twist_q  [NumTerms];
  field_t     coef     [NumLanes][NumTerms];
  field_t     lane_res [NumLanes];
  logic [NumLanes-1:0] lane_sat;
  field_t     res_q    [NumLanes];
  logic       sat_q;
  logic [3:0] vld_q;
  logic [3:0] vld_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       adv;
  logic       load_en;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign load_en    = in_valid_i && adv && (kind_i == KindLoad)
                      && (entry_index_i < IdxW'(StoreDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < StoreDepth; e++) begin
        store_q[e] <= '0;
      end
    end else if (load_en) begin
      store_q[entry_index_i] <= entry_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      twist_q[0] <= ang_x_i;
      twist_q[1] <= ang_y_i;
      twist_q[2] <= ang_z_i;
      twist_q[3] <= lin_x_i;
      twist_q[4] <= lin_y_i;
      twist_q[5] <= lin_z_i;
    end
  end

  // lanes 0..2 force, 3..5 torque; terms 0..2 angular, 3..5 linear
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        coef[i][k]       = store_q[HBase + k*3 + i];
        coef[i][3+k]     = store_q[MBase + i*3 + k];
        coef[3+i][k]     = store_q[JBase + i*3 + k];
        coef[3+i][3+k]   = store_q[HBase + i*3 + k];
      end
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    sitm_lane u_lane (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .coef_i  (coef[g]),
      .twist_i (twist_q),
      .res_o   (lane_res[g]),
      .sat_o   (lane_sat[g])
    );
  end

  always_comb begin
    vld_d       = vld_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      vld_d       = {vld_q[2:0], in_valid_i && (kind_i == KindMultiply)};
      out_valid_d = vld_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= lane_res;
      sat_q <= |lane_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign force_x_o   = res_q[0];
  assign force_y_o   = res_q[1];
  assign force_z_o   = res_q[2];
  assign torque_x_o  = res_q[3];
  assign torque_y_o  = res_q[4];
  assign torque_z_o  = res_q[5];
  assign saturated_o = sat_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("in_ready_o low with empty output stage");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q))
    else $error("pipeline moved during output stall");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KindLoad) |=> !vld_q[0])
    else $error("load request entered the multiply pipeline");

endmodule

`default_nettype wire
